>>> hdl/mct_pkg.sv
`default_nettype none

package mct_pkg;

    // Default structural parameters
    localparam int DEFAULT_CLOCKS_PER_BEAT = 24;
    localparam int DEFAULT_TIME_BITS       = 48;

    // Field widths
    localparam int BPM_W      = 17;
    localparam int ALPHA_W    = 9;
    localparam int THR_W      = 16;
    localparam int TMO_W      = 24;
    localparam int STAMP_W    = 48;
    localparam int BYTE_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;
    localparam int PROD_W     = ALPHA_W + BPM_W;

    // Raw tempo numerator: 60e6 us per minute in Q26.8
    localparam int                DIVIDEND_W    = 34;
    localparam logic [DIVIDEND_W-1:0] RAW_NUMERATOR = 34'd15360000000;

    // Full weight in Q1.8
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Register reset values
    localparam logic [BPM_W-1:0]   MIN_BPM_RST      = 17'd10240;
    localparam logic [BPM_W-1:0]   MAX_BPM_RST      = 17'd76800;
    localparam logic [ALPHA_W-1:0] ALPHA_STEADY_RST = 9'd51;
    localparam logic [ALPHA_W-1:0] ALPHA_CHANGE_RST = 9'd230;
    localparam logic [THR_W-1:0]   THRESHOLD_RST    = 16'd1311;
    localparam logic [BPM_W-1:0]   DEFAULT_BPM_RST  = 17'd30720;
    localparam logic [TMO_W-1:0]   TIMEOUT_RST      = 24'd1000000;

    // MIDI real-time status bytes
    localparam logic [BYTE_W-1:0] RT_CLOCK    = 8'hF8;
    localparam logic [BYTE_W-1:0] RT_START    = 8'hFA;
    localparam logic [BYTE_W-1:0] RT_CONTINUE = 8'hFB;
    localparam logic [BYTE_W-1:0] RT_STOP     = 8'hFC;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_CLOCK    = 3'd1,
        KIND_START    = 3'd2,
        KIND_CONTINUE = 3'd3,
        KIND_STOP     = 3'd4
    } t_kind;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MIN_BPM      = 3'd0,
        REG_MAX_BPM      = 3'd1,
        REG_ALPHA_STEADY = 3'd2,
        REG_ALPHA_CHANGE = 3'd3,
        REG_THRESHOLD    = 3'd4,
        REG_DEFAULT_BPM  = 3'd5,
        REG_TIMEOUT      = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [BPM_W-1:0]   min_bpm;
        logic [BPM_W-1:0]   max_bpm;
        logic [ALPHA_W-1:0] alpha_steady;
        logic [ALPHA_W-1:0] alpha_change;
        logic [THR_W-1:0]   chg_thresh;
        logic [BPM_W-1:0]   default_bpm;
        logic [TMO_W-1:0]   active_timeout;
    } t_cfg;

    // Classified request tag carried through the queue
    typedef struct packed {
        logic  tempo_reset;
        t_kind kind;
    } t_tag;

endpackage

`default_nettype wire

>>> hdl/mct_queue.sv
`default_nettype none

module mct_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Store incoming request
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/mct_front.sv
`default_nettype none

module mct_front
    import mct_pkg::*;
#(
    parameter int TIME_BITS = DEFAULT_TIME_BITS
) (
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [IN_DATA_W-1:0] i_s_tdata,  // [7:0] midi_byte, [55:8] timestamp_us
    input  wire logic [0:0]           i_s_tuser,  // [0] mode
    input  wire logic                 i_full,
    output logic                      o_push,
    output t_tag                      o_tag,
    output logic [TIME_BITS-1:0]      o_time
);

    logic [BYTE_W-1:0]  w_byte;
    logic [STAMP_W-1:0] w_stamp;
    t_kind              w_kind;

    assign w_byte  = i_s_tdata[BYTE_W-1:0];
    assign w_stamp = i_s_tdata[BYTE_W +: STAMP_W];

    // Classify real-time bytes
    always_comb begin
        case (w_byte)
            RT_CLOCK:    w_kind = KIND_CLOCK;
            RT_START:    w_kind = KIND_START;
            RT_CONTINUE: w_kind = KIND_CONTINUE;
            RT_STOP:     w_kind = KIND_STOP;
            default:     w_kind = KIND_NONE;
        endcase
    end

    // Tempo reset request carries no message
    assign o_tag.tempo_reset = i_s_tuser[0];
    assign o_tag.kind        = i_s_tuser[0] ? KIND_NONE : w_kind;
    assign o_time            = TIME_BITS'(w_stamp);

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

endmodule

`default_nettype wire

>>> hdl/mct_div.sv
`default_nettype none

module mct_div
    import mct_pkg::*;
#(
    parameter int TIME_BITS = DEFAULT_TIME_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [TIME_BITS-1:0] i_divisor,
    output logic                      o_done,
    output logic [DIVIDEND_W-1:0]     o_quot
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [TIME_BITS-1:0]  r_div;
    logic [TIME_BITS-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [TIME_BITS:0]    w_rem_sh;
    logic [TIME_BITS:0]    w_rem_sub;
    logic                  w_ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign w_rem_sh  = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_sub = w_rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= RAW_NUMERATOR;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_rem_sub[TIME_BITS-1:0] : w_rem_sh[TIME_BITS-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
        end
    end

    // Step counter, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

>>> hdl/mct_back.sv
`default_nettype none

module mct_back
    import mct_pkg::*;
#(
    parameter int CLOCKS_PER_BEAT = DEFAULT_CLOCKS_PER_BEAT,
    parameter int TIME_BITS       = DEFAULT_TIME_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire logic                 i_q_valid,
    output logic                      o_q_pop,
    input  wire t_tag                 i_q_tag,
    input  wire logic [TIME_BITS-1:0] i_q_time,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [OUT_DATA_W-1:0]     o_m_tdata,
    output logic [2:0]                o_m_tuser
);

    localparam int CNT_W = $clog2(CLOCKS_PER_BEAT + 1);
    localparam int MUL_W = BPM_W + THR_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_CHK  = 7'b0000100,
        S_CMP  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_SUM  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic                  r_latched;
    logic [TIME_BITS-1:0]  r_latch_time;
    logic [CNT_W-1:0]      r_cnt;
    logic [BPM_W-1:0]      r_smooth;
    logic [BPM_W-1:0]      r_raw_held;
    logic                  r_ready;
    logic [TIME_BITS-1:0]  r_now;
    t_kind                 r_kind;
    logic [BPM_W-1:0]      r_raw;
    logic [BPM_W-1:0]      r_diff;
    logic [MUL_W-1:0]      r_thr_prod;
    logic [ALPHA_W-1:0]    r_alpha;
    logic [PROD_W-1:0]     r_p1;
    logic [PROD_W-1:0]     r_p2;
    logic                  r_o_valid;
    logic [OUT_DATA_W-1:0] r_o_data;
    logic [2:0]            r_o_user;

    logic                  w_pop;
    logic [CNT_W-1:0]      w_cnt_inc;
    logic                  w_beat;
    logic [TIME_BITS-1:0]  w_interval;
    logic                  w_measure;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [DIVIDEND_W-1:0] w_quot;
    logic                  w_in_range;
    logic [BPM_W-1:0]      w_quot_lo;
    logic                  w_large;
    logic [ALPHA_W-1:0]    w_alpha_sel;
    logic [PROD_W:0]       w_sum;
    logic [TIME_BITS-1:0]  w_elapsed;
    logic                  w_active;
    logic                  w_out_free;

    // Request decode in idle
    assign w_pop       = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop     = w_pop;
    assign w_cnt_inc   = r_cnt + CNT_W'(1);
    assign w_beat      = (w_cnt_inc >= CNT_W'(CLOCKS_PER_BEAT));
    assign w_interval  = i_q_time - r_latch_time;
    assign w_measure   = !i_q_tag.tempo_reset && (i_q_tag.kind == KIND_CLOCK)
                         && r_latched && w_beat;
    assign w_div_start = w_pop && w_measure && (w_interval != '0);

    mct_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_divisor (w_interval),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    // Range test and blend arithmetic
    assign w_in_range  = !(w_quot < DIVIDEND_W'(i_cfg.min_bpm))
                         && !(w_quot > DIVIDEND_W'(i_cfg.max_bpm));
    assign w_quot_lo   = w_quot[BPM_W-1:0];
    assign w_large     = (r_smooth == '0) || ({r_diff, 16'b0} > r_thr_prod);
    assign w_alpha_sel = w_large ? i_cfg.alpha_change : i_cfg.alpha_steady;
    assign w_sum       = {1'b0, r_p1} + {1'b0, r_p2};

    // Activity after the update
    assign w_elapsed  = r_now - r_latch_time;
    assign w_active   = r_latched && (w_elapsed < TIME_BITS'(i_cfg.active_timeout));
    assign w_out_free = !r_o_valid || i_m_tready;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_pop) begin
                    n_state = w_div_start ? S_DIV : S_OUT;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK:   n_state = w_in_range ? S_CMP : S_OUT;
            S_CMP:   n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Tempo state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched    <= 1'b0;
            r_latch_time <= '0;
            r_cnt        <= '0;
            r_smooth     <= DEFAULT_BPM_RST;
            r_raw_held   <= DEFAULT_BPM_RST;
            r_ready      <= 1'b0;
        end else begin
            if (w_pop) begin
                if (i_q_tag.tempo_reset) begin
                    r_smooth     <= i_cfg.default_bpm;
                    r_raw_held   <= i_cfg.default_bpm;
                    r_latched    <= 1'b0;
                    r_latch_time <= '0;
                    r_cnt        <= '0;
                    r_ready      <= 1'b0;
                end else if (i_q_tag.kind == KIND_START) begin
                    r_latched    <= 1'b0;
                    r_latch_time <= '0;
                    r_cnt        <= '0;
                    r_ready      <= 1'b0;
                end else if (i_q_tag.kind == KIND_CLOCK) begin
                    if (!r_latched) begin
                        r_latched    <= 1'b1;
                        r_latch_time <= i_q_time;
                        r_cnt        <= '0;
                    end else if (w_beat) begin
                        r_latch_time <= i_q_time;
                        r_cnt        <= '0;
                    end else begin
                        r_cnt <= w_cnt_inc;
                    end
                end
            end
            if (r_state == S_SUM) begin
                r_smooth   <= w_sum[BPM_W+7:8];
                r_raw_held <= r_raw;
                r_ready    <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_now  <= i_q_time;
            r_kind <= i_q_tag.kind;
        end
        if (r_state == S_CHK) begin
            r_raw      <= w_quot_lo;
            r_diff     <= (w_quot_lo > r_smooth) ? w_quot_lo - r_smooth
                                                 : r_smooth - w_quot_lo;
            r_thr_prod <= i_cfg.chg_thresh * r_smooth;
        end
        if (r_state == S_CMP) begin
            r_alpha <= (w_alpha_sel > ALPHA_ONE) ? ALPHA_ONE : w_alpha_sel;
        end
        if (r_state == S_MUL) begin
            r_p1 <= r_alpha * r_raw;
            r_p2 <= (ALPHA_ONE - r_alpha) * r_smooth;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_o_data <= {4'b0, w_active, r_ready, r_raw_held, r_smooth};
            r_o_user <= r_kind;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_user;

    // The divider only runs on a nonzero interval
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (w_interval != '0))
        else $error("divider started on zero interval");

    // A measurement in flight implies a latched time
    a_div_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_latched)
        else $error("measurement without latched time");

    // A blend sets the ready flag
    a_blend_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |=> r_ready)
        else $error("ready flag not set after blend");

    // A tempo reset clears the latch and counter
    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_q_tag.tempo_reset) |=> (!r_latched && r_cnt == '0 && !r_ready))
        else $error("tempo reset left state behind");

    // The stored clock count stays below one beat
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(CLOCKS_PER_BEAT))
        else $error("clock counter past beat length");

endmodule

`default_nettype wire

>>> hdl/midi_clock_tempo_tracker_core.sv
// Channel   Dir  Handshake              Payload
// s (req)   in   i_s_tvalid/o_s_tready  tdata: midi_byte, timestamp_us; tuser: mode
// m (res)   out  o_m_tvalid/i_m_tready  tdata: tempo, raw tempo, ready, active; tuser: kind
// cfg       in   i_cfg_valid/o_cfg_ready  i_cfg_addr register index, i_cfg_wdata value
//
// A request without a tempo measurement goes from idle straight to the output state.
// A beat-closing clock runs through the bit-serial divider (34 quotient bits,
// one per cycle), then range check and, if in range, compare, multiply and sum.
// The front queue takes up to 4 requests while a measurement runs or a result
// waits in the output register; o_s_tready drops once it is full.
// Reset (synchronous, active low) loads all register defaults; no clearing pass.
`default_nettype none

module midi_clock_tempo_tracker_core
    import mct_pkg::*;
#(
    parameter int CLOCKS_PER_BEAT = DEFAULT_CLOCKS_PER_BEAT,
    parameter int TIME_BITS       = DEFAULT_TIME_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,   // [7:0] midi_byte, [55:8] timestamp_us
    input  wire logic [0:0]            i_s_tuser,   // [0] mode
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,   // [16:0] tempo_bpm, [33:17] raw_tempo_bpm,
                                                    // [34] tempo_valid, [35] clock_active,
                                                    // [39:36] zero
    output logic [2:0]                 o_m_tuser,   // [2:0] message_kind
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int Q_W = $bits(t_tag) + TIME_BITS;

    t_cfg                 r_cfg;
    logic                 w_push;
    t_tag                 w_push_tag;
    logic [TIME_BITS-1:0] w_push_time;
    logic                 w_full;
    logic                 w_q_valid;
    logic                 w_q_pop;
    logic [Q_W-1:0]       w_q_data;
    t_tag                 w_q_tag;
    logic [TIME_BITS-1:0] w_q_time;

    // Configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_bpm        <= MIN_BPM_RST;
            r_cfg.max_bpm        <= MAX_BPM_RST;
            r_cfg.alpha_steady   <= ALPHA_STEADY_RST;
            r_cfg.alpha_change   <= ALPHA_CHANGE_RST;
            r_cfg.chg_thresh     <= THRESHOLD_RST;
            r_cfg.default_bpm    <= DEFAULT_BPM_RST;
            r_cfg.active_timeout <= TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_MIN_BPM:      r_cfg.min_bpm        <= i_cfg_wdata[BPM_W-1:0];
                REG_MAX_BPM:      r_cfg.max_bpm        <= i_cfg_wdata[BPM_W-1:0];
                REG_ALPHA_STEADY: r_cfg.alpha_steady   <= i_cfg_wdata[ALPHA_W-1:0];
                REG_ALPHA_CHANGE: r_cfg.alpha_change   <= i_cfg_wdata[ALPHA_W-1:0];
                REG_THRESHOLD:    r_cfg.chg_thresh     <= i_cfg_wdata[THR_W-1:0];
                REG_DEFAULT_BPM:  r_cfg.default_bpm    <= i_cfg_wdata[BPM_W-1:0];
                REG_TIMEOUT:      r_cfg.active_timeout <= i_cfg_wdata[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    mct_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_tag      (w_push_tag),
        .o_time     (w_push_time)
    );

    mct_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_tag, w_push_time}),
        .o_full  (w_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_q_tag  = w_q_data[Q_W-1 -: $bits(t_tag)];
    assign w_q_time = w_q_data[TIME_BITS-1:0];

    mct_back #(
        .CLOCKS_PER_BEAT (CLOCKS_PER_BEAT),
        .TIME_BITS       (TIME_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (w_q_valid),
        .o_q_pop    (w_q_pop),
        .i_q_tag    (w_q_tag),
        .i_q_time   (w_q_time),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire
